// ===== rtl/tsbs_pkg.sv =====
// Package for the timed serial bit shifter: beat payload types, the
// configuration register set, command codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsbs_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned TICKS_W    = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SETUP_TICKS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TICKS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_READ_HALF_TICKS = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [WORD_W-1:0]  shift_word;
      logic [COUNT_W-1:0] bit_count;
      logic               pin_in;
   } tsbs_req_type;

   typedef struct packed {
      logic              clock_level;
      logic              data_level;
      logic              busy_res;
      logic              done_res;
      logic [WORD_W-1:0] read_word;
   } tsbs_rsp_type;

   typedef struct packed {
      logic [TICKS_W-1:0] setup_ticks;
      logic [TICKS_W-1:0] hold_ticks;
      logic [TICKS_W-1:0] read_half_ticks;
   } tsbs_cfg_type;

endpackage

`default_nettype wire

// ===== rtl/tsbs_engine.sv =====
// Shift engine: holds the command state and works out the next state and
// the result of one accepted beat combinationally.
// Depends on tsbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsbs_engine #(
   parameter int unsigned MAX_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire tsbs_pkg::tsbs_req_type req,
   input  wire tsbs_pkg::tsbs_cfg_type cfg,
   output tsbs_pkg::tsbs_rsp_type      rsp
);

   localparam int unsigned CNT_W = $clog2(MAX_BITS + 1);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WRITE,
      MODE_READ
   } mode_type;

   mode_type                          mode_ff, mode_in;
   logic                              phase_high_ff, phase_high_in;
   logic [tsbs_pkg::WORD_W-1:0]       shift_ff, shift_in;
   logic [CNT_W-1:0]                  bits_left_ff, bits_left_in;
   logic [tsbs_pkg::TICKS_W-1:0]      ticks_ff, ticks_in;
   logic [CNT_W-1:0]                  pos_ff, pos_in;
   logic [tsbs_pkg::WORD_W-1:0]       in_word_ff, in_word_in;
   logic                              data_ff, data_in;
   logic                              done;

   logic [CNT_W-1:0]                  count;
   logic [tsbs_pkg::TICKS_W-1:0]      ticks_dec;
   logic [CNT_W-1:0]                  bits_dec;
   logic [7:0]                        pos_wide;
   logic [tsbs_pkg::TICKS_W-1:0]      setup_min;
   logic [tsbs_pkg::TICKS_W-1:0]      hold_min;
   logic [tsbs_pkg::TICKS_W-1:0]      half_min;

   assign setup_min = (cfg.setup_ticks == '0) ? tsbs_pkg::TICKS_W'(1) : cfg.setup_ticks;
   assign hold_min  = (cfg.hold_ticks == '0) ? tsbs_pkg::TICKS_W'(1) : cfg.hold_ticks;
   assign half_min  = (cfg.read_half_ticks == '0) ? tsbs_pkg::TICKS_W'(1)
                                                  : cfg.read_half_ticks;

   assign count = (8'(req.bit_count) > 8'(MAX_BITS)) ? CNT_W'(MAX_BITS)
                                                     : CNT_W'(req.bit_count);
   assign ticks_dec = ticks_ff - tsbs_pkg::TICKS_W'(1);
   assign bits_dec  = bits_left_ff - CNT_W'(1);
   assign pos_wide  = 8'(pos_ff);

   always_comb begin
      mode_in       = mode_ff;
      phase_high_in = phase_high_ff;
      shift_in      = shift_ff;
      bits_left_in  = bits_left_ff;
      ticks_in      = ticks_ff;
      pos_in        = pos_ff;
      in_word_in    = in_word_ff;
      data_in       = data_ff;
      done          = 1'b0;
      case (req.kind)
         tsbs_pkg::KIND_TICK: begin
            if (mode_ff != MODE_IDLE) begin
               ticks_in = ticks_dec;
               if (ticks_dec == '0) begin
                  if (phase_high_ff) begin
                     phase_high_in = 1'b0;
                     if (mode_ff == MODE_READ) begin
                        ticks_in = half_min;
                        if (req.pin_in && pos_wide < 8'd32) begin
                           in_word_in[pos_wide[4:0]] = 1'b1;
                        end
                     end else begin
                        ticks_in = hold_min;
                     end
                  end else begin
                     bits_left_in = bits_dec;
                     if (mode_ff == MODE_READ) begin
                        pos_in = pos_ff + CNT_W'(1);
                     end else begin
                        shift_in = shift_ff >> 1;
                     end
                     if (bits_dec == '0) begin
                        mode_in = MODE_IDLE;
                        done    = 1'b1;
                        if (mode_ff == MODE_READ) begin
                           data_in = 1'b0;
                        end
                     end else begin
                        phase_high_in = 1'b1;
                        if (mode_ff == MODE_READ) begin
                           ticks_in = half_min;
                        end else begin
                           data_in  = shift_ff[1];
                           ticks_in = setup_min;
                        end
                     end
                  end
               end
            end
         end
         tsbs_pkg::KIND_WRITE: begin
            if (mode_ff == MODE_IDLE) begin
               if (count == '0) begin
                  done = 1'b1;
               end else begin
                  shift_in      = req.shift_word;
                  bits_left_in  = count;
                  phase_high_in = 1'b1;
                  data_in       = req.shift_word[0];
                  ticks_in      = setup_min;
                  mode_in       = MODE_WRITE;
               end
            end
         end
         tsbs_pkg::KIND_READ: begin
            if (mode_ff == MODE_IDLE) begin
               in_word_in = '0;
               pos_in     = '0;
               if (count == '0) begin
                  data_in = 1'b0;
                  done    = 1'b1;
               end else begin
                  bits_left_in  = count;
                  data_in       = 1'b1;
                  phase_high_in = 1'b1;
                  ticks_in      = half_min;
                  mode_in       = MODE_READ;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.clock_level = phase_high_in;
      rsp.data_level  = data_in;
      rsp.busy_res    = (mode_in != MODE_IDLE);
      rsp.done_res    = done;
      rsp.read_word   = in_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         phase_high_ff <= 1'b0;
         shift_ff      <= '0;
         bits_left_ff  <= '0;
         ticks_ff      <= '0;
         pos_ff        <= '0;
         in_word_ff    <= '0;
         data_ff       <= 1'b0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         phase_high_ff <= phase_high_in;
         shift_ff      <= shift_in;
         bits_left_ff  <= bits_left_in;
         ticks_ff      <= ticks_in;
         pos_ff        <= pos_in;
         in_word_ff    <= in_word_in;
         data_ff       <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tsbs_out_skid.sv =====
// Result buffer: an output register with one skid entry behind it, so a new
// beat can enter while a finished result waits. Depends on tsbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsbs_out_skid (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire tsbs_pkg::tsbs_rsp_type in_data,
   output logic                       in_stall,
   output logic                       out_valid,
   output tsbs_pkg::tsbs_rsp_type      out_data,
   input  wire logic                  out_stall
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   tsbs_pkg::tsbs_rsp_type main_ff, main_in;
   tsbs_pkg::tsbs_rsp_type skid_ff, skid_in;
   logic                   in_fire;
   logic                   out_fire;

   assign in_stall  = skid_valid_ff;
   assign in_fire   = in_valid && !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign out_fire  = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_fire;
         end
      end else if (in_fire) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ===== rtl/timed_serial_bit_shifter.sv =====
// Top level of the timed serial bit shifter: configuration registers, the
// shift engine and the result buffer. Depends on tsbs_pkg, tsbs_engine and
// tsbs_out_skid.
//
//   Channel  Direction  Ports                         Beat
//   req      in         req_valid req_stall req_data  command or one tick
//   rsp      out        rsp_valid rsp_stall rsp_data  line levels and status
//   csr      in         csr_we csr_index csr_wdata    register write
//
// One request beat is taken per clock while req_stall is low; its result
// is registered with the engine state. Reset is synchronous and clears
// the state, the registers and the buffer. A stalled result stays in the
// output register; one more beat goes into the skid entry, and req_stall
// rises only while that entry is full.
`timescale 1ns / 1ps
`default_nettype none

module timed_serial_bit_shifter #(
   parameter int unsigned MAX_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire tsbs_pkg::tsbs_req_type               req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output tsbs_pkg::tsbs_rsp_type                    rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [tsbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tsbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tsbs_pkg::tsbs_cfg_type cfg_ff;
   tsbs_pkg::tsbs_rsp_type step_rsp;
   logic                   req_fire;

   assign req_fire = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tsbs_pkg::REG_SETUP_TICKS:     cfg_ff.setup_ticks     <= csr_wdata;
            tsbs_pkg::REG_HOLD_TICKS:      cfg_ff.hold_ticks      <= csr_wdata;
            tsbs_pkg::REG_READ_HALF_TICKS: cfg_ff.read_half_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tsbs_engine #(
      .MAX_BITS (MAX_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (req_fire),
      .req   (req_data),
      .cfg   (cfg_ff),
      .rsp   (step_rsp)
   );

   tsbs_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .in_data   (step_rsp),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

endmodule

`default_nettype wire
